@@ src/pdq_pkg.sv @@
// Package for the plate debounce queue counter: sizes, register codes, control types.
package pdq_pkg;

	localparam int unsigned PLATES     = 8;
	localparam int unsigned IN_BITS    = 8;
	localparam int unsigned RAW_W      = (PLATES > IN_BITS) ? PLATES : IN_BITS;
	localparam int unsigned IDX_W      = (PLATES > 1) ? $clog2(PLATES) : 1;
	localparam int unsigned HOLD_W     = 16;
	localparam int unsigned DIST_W     = 12;
	localparam int unsigned STEP_W     = DIST_W + 1;
	localparam int unsigned CNT_W      = 4;
	localparam int unsigned EST_W      = 15;
	localparam int unsigned FACT_W     = CNT_W + 2;
	localparam int unsigned PROD_W     = FACT_W + STEP_W;
	localparam int unsigned SUM_W      = PROD_W + 1;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned DIV_STEPS  = DIST_W;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [EST_W-1:0] EST_MAX = '1;

	localparam logic [HOLD_W-1:0] HOLD_TICKS_RST       = 16'd1000;
	localparam logic [DIST_W-1:0] PERSON_WIDTH_RST     = 12'd50;
	localparam logic [DIST_W-1:0] PERSON_GAP_RST       = 12'd30;
	localparam logic [DIST_W-1:0] FIRST_PLATE_SPAN_RST = 12'd200;
	localparam logic [DIST_W-1:0] FRONT_OFFSET_RST     = 12'd40;
	localparam logic [DIST_W-1:0] PLATE_SPACING_RST    = 12'd160;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD_TICKS       = 3'd0,
		CFG_PERSON_WIDTH     = 3'd1,
		CFG_PERSON_GAP       = 3'd2,
		CFG_FIRST_PLATE_SPAN = 3'd3,
		CFG_FRONT_OFFSET     = 3'd4,
		CFG_PLATE_SPACING    = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		DIV_FIRST   = 1'b0,
		DIV_BETWEEN = 1'b1
	} div_sel_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DEB  = 8'b0000_0010,
		ST_SCAN = 8'b0000_0100,
		ST_DIV1 = 8'b0000_1000,
		ST_DIV2 = 8'b0001_0000,
		ST_MUL  = 8'b0010_0000,
		ST_EST  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic     in_ready;
		logic     deb;
		logic     scan;
		logic     div_start;
		div_sel_t div_sel;
		logic     cap_first;
		logic     cap_between;
		logic     mul;
		logic     est;
		logic     out_load;
	} pdq_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic scan_last;
		logic div_done;
		logic out_free;
	} pdq_sts_t;

endpackage

@@ src/pdq_if.sv @@
// Handshake interfaces for the tick input and the report output.
interface pdq_in_if;
	import pdq_pkg::*;
	logic               valid;
	logic               ready;
	logic [IN_BITS-1:0] plate_levels;
	modport source (output valid, output plate_levels, input ready);
	modport sink (input valid, input plate_levels, output ready);
endinterface

interface pdq_out_if;
	import pdq_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] pressed_count;
	logic [EST_W-1:0] people_estimate;
	logic             count_changed;
	modport source (output valid, output pressed_count, output people_estimate,
		output count_changed, input ready);
	modport sink (input valid, input pressed_count, input people_estimate,
		input count_changed, output ready);
endinterface

@@ src/pdq_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module pdq_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pdq_pkg::DIST_W-1:0]  num,
	input  logic [pdq_pkg::STEP_W-1:0]  den,
	output logic                        done,
	output logic [pdq_pkg::DIST_W-1:0]  quo
);
	import pdq_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [STEP_W-1:0]    den_q;
	logic [STEP_W-1:0]    rem_q;
	logic [DIST_W-1:0]    quo_q;
	logic [STEP_W:0]      trial;
	logic                 fits;
	logic                 last;

	assign trial = {rem_q, quo_q[DIST_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign last  = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? STEP_W'(trial - {1'b0, den_q}) : trial[STEP_W-1:0];
			quo_q <= {quo_q[DIST_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last && !start) |=> done_q)
		else $error("divider finished without done");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && den_q != '0) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

endmodule

@@ src/pdq_ctrl.sv @@
// Controller state machine sequencing debounce, scan, divisions, multiply, estimate and output load.
module pdq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  pdq_pkg::pdq_sts_t  sts,
	output pdq_pkg::pdq_cmd_t  cmd
);
	import pdq_pkg::*;

	state_t state_q;
	state_t state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					state_n = ST_DEB;
				end
			end
			ST_DEB: begin
				cmd.deb = 1'b1;
				state_n = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_FIRST;
					state_n       = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (sts.div_done) begin
					cmd.cap_first = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_BETWEEN;
					state_n       = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (sts.div_done) begin
					cmd.cap_between = 1'b1;
					state_n         = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_EST;
			end
			ST_EST: begin
				cmd.est = 1'b1;
				state_n = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && sts.in_valid) |=> (state_q == ST_DEB))
		else $error("accepted word did not start debounce");
	a_div2_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV2 && sts.div_done) |=> (state_q == ST_MUL))
		else $error("second quotient not followed by multiply");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten");

endmodule

@@ src/pdq_dp.sv @@
// Datapath: config registers, debounce state, plate scan, estimate and output register.
module pdq_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	pdq_in_if.sink                         tick,
	pdq_out_if.source                      report,
	input  logic                           cfg_we,
	input  logic [pdq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  pdq_pkg::pdq_cmd_t              cmd,
	output pdq_pkg::pdq_sts_t              sts
);
	import pdq_pkg::*;

	logic [HOLD_W-1:0] hold_ticks_q;
	logic [DIST_W-1:0] person_width_q;
	logic [DIST_W-1:0] person_gap_q;
	logic [DIST_W-1:0] first_plate_span_q;
	logic [DIST_W-1:0] front_offset_q;
	logic [DIST_W-1:0] plate_spacing_q;

	logic [IN_BITS-1:0] levels_q;
	logic [PLATES-1:0]  acc_q;
	logic [HOLD_W-1:0]  timer_q [PLATES];
	logic [PLATES-1:0]  acc_n;
	logic [HOLD_W-1:0]  timer_n [PLATES];
	logic [RAW_W-1:0]   raw_pad;
	logic [PLATES-1:0]  raw;

	logic [PLATES-1:0] scan_q;
	logic [IDX_W-1:0]  idx_q;
	logic              stop_q;
	logic              prev_rel_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  last_count_q;

	logic [STEP_W-1:0]        step;
	logic [STEP_W-1:0]        diff;
	logic                     diff_neg;
	logic [STEP_W-1:0]        diff_mag;
	logic [DIST_W-1:0]        div_num;
	logic                     div_done;
	logic [DIST_W-1:0]        div_quo;
	logic [STEP_W-1:0]        quo_ext;
	logic signed [STEP_W-1:0] first_q;
	logic [DIST_W-1:0]        between_q;

	logic signed [FACT_W-1:0] factor;
	logic signed [STEP_W-1:0] btw_s;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum;

	logic [CNT_W-1:0] res_count_q;
	logic [EST_W-1:0] res_est_q;
	logic             res_chg_q;
	logic             rv_q;
	logic [CNT_W-1:0] out_count_q;
	logic [EST_W-1:0] out_est_q;
	logic             out_chg_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q       <= HOLD_TICKS_RST;
			person_width_q     <= PERSON_WIDTH_RST;
			person_gap_q       <= PERSON_GAP_RST;
			first_plate_span_q <= FIRST_PLATE_SPAN_RST;
			front_offset_q     <= FRONT_OFFSET_RST;
			plate_spacing_q    <= PLATE_SPACING_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HOLD_TICKS:       hold_ticks_q       <= cfg_data;
				CFG_PERSON_WIDTH:     person_width_q     <= cfg_data[DIST_W-1:0];
				CFG_PERSON_GAP:       person_gap_q       <= cfg_data[DIST_W-1:0];
				CFG_FIRST_PLATE_SPAN: first_plate_span_q <= cfg_data[DIST_W-1:0];
				CFG_FRONT_OFFSET:     front_offset_q     <= cfg_data[DIST_W-1:0];
				CFG_PLATE_SPACING:    plate_spacing_q    <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign tick.ready = cmd.in_ready;

	always_ff @(posedge clk) begin
		if (tick.valid && cmd.in_ready) begin
			levels_q <= tick.plate_levels;
		end
	end

	// Plates without an input bit read as released.
	always_comb begin
		raw_pad                = '1;
		raw_pad[IN_BITS-1:0]   = levels_q;
		raw                    = raw_pad[PLATES-1:0];
		for (int i = 0; i < PLATES; i++) begin
			acc_n[i]   = acc_q[i];
			timer_n[i] = '0;
			if (raw[i] != acc_q[i]) begin
				if (timer_q[i] > hold_ticks_q) begin
					acc_n[i] = raw[i];
				end else if (timer_q[i] != '1) begin
					timer_n[i] = timer_q[i] + 1'b1;
				end else begin
					timer_n[i] = timer_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '1;
			last_count_q <= '0;
			for (int i = 0; i < PLATES; i++) begin
				timer_q[i] <= '0;
			end
		end else begin
			if (cmd.deb) begin
				acc_q <= acc_n;
				for (int i = 0; i < PLATES; i++) begin
					timer_q[i] <= timer_n[i];
				end
			end
			if (cmd.est) begin
				last_count_q <= count_q;
			end
		end
	end

	// Scan walks the accepted levels from plate zero, one plate per cycle.
	always_ff @(posedge clk) begin
		if (cmd.deb) begin
			scan_q     <= acc_n;
			idx_q      <= '0;
			stop_q     <= 1'b0;
			prev_rel_q <= 1'b0;
			count_q    <= '0;
		end else if (cmd.scan) begin
			scan_q     <= scan_q >> 1;
			idx_q      <= idx_q + 1'b1;
			prev_rel_q <= scan_q[0];
			if (!stop_q) begin
				if (!scan_q[0]) begin
					if (count_q != CNT_MAX) begin
						count_q <= count_q + 1'b1;
					end
				end else if (prev_rel_q) begin
					stop_q <= 1'b1;
				end
			end
		end
	end

	assign step     = {1'b0, person_width_q} + {1'b0, person_gap_q};
	assign diff     = {1'b0, first_plate_span_q} - {1'b0, front_offset_q};
	assign diff_neg = diff[STEP_W-1];
	assign diff_mag = diff_neg ? STEP_W'(-diff) : diff;
	assign div_num  = (cmd.div_sel == DIV_FIRST) ? diff_mag[DIST_W-1:0] : plate_spacing_q;
	assign quo_ext  = {1'b0, div_quo};

	pdq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (step),
		.done   (div_done),
		.quo    (div_quo)
	);

	// A zero step yields zero quotients.
	always_ff @(posedge clk) begin
		if (cmd.cap_first) begin
			if (step == '0) begin
				first_q <= '0;
			end else begin
				first_q <= diff_neg ? $signed(STEP_W'(-quo_ext)) : $signed(quo_ext);
			end
		end
		if (cmd.cap_between) begin
			between_q <= (step == '0) ? '0 : div_quo;
		end
	end

	assign factor = $signed({2'b00, count_q}) - (acc_q[0] ? FACT_W'(1) : FACT_W'(0));
	assign btw_s  = $signed({1'b0, between_q});
	assign sum    = $signed({prod_q[PROD_W-1], prod_q})
		+ (acc_q[0] ? $signed({{(SUM_W-STEP_W){first_q[STEP_W-1]}}, first_q})
			: $signed(SUM_W'(0)));

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= factor * btw_s;
		end
		if (cmd.est) begin
			res_count_q <= count_q;
			res_chg_q   <= count_q != last_count_q;
			if (sum < 0) begin
				res_est_q <= '0;
			end else if (sum > $signed({{(SUM_W-EST_W){1'b0}}, EST_MAX})) begin
				res_est_q <= EST_MAX;
			end else begin
				res_est_q <= sum[EST_W-1:0];
			end
		end
		if (cmd.out_load) begin
			out_count_q <= res_count_q;
			out_est_q   <= res_est_q;
			out_chg_q   <= res_chg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (cmd.out_load) begin
			rv_q <= 1'b1;
		end else if (report.ready) begin
			rv_q <= 1'b0;
		end
	end

	assign report.valid           = rv_q;
	assign report.pressed_count   = out_count_q;
	assign report.people_estimate = out_est_q;
	assign report.count_changed   = out_chg_q;

	assign sts.in_valid  = tick.valid;
	assign sts.scan_last = idx_q == IDX_W'(PLATES - 1);
	assign sts.div_done  = div_done;
	assign sts.out_free  = !rv_q || report.ready;

endmodule

@@ src/plate_debounce_queue_counter.sv @@
// Top level of the plate debounce queue counter.
//
//  Channel   Dir  Handshake          Payload
//  tick      in   valid / ready      plate_levels[7:0]
//  report    out  valid / ready      pressed_count[3:0], people_estimate[14:0], count_changed
//  cfg       in   cfg_we             cfg_index[2:0], cfg_data[15:0]
//
// Each tick word goes from acceptance to its loaded report through a debounce step,
// a scan over all plates, two divisions one after the other in the shared divider,
// then a multiply, an estimate and a load step.
// Reset clears the debounce state, restores the register defaults and empties the output.
// A waiting report does not block the next tick word; only a second finished report
// stalls in the controller until the output register is taken.
module plate_debounce_queue_counter (
	input  logic                           clk,
	input  logic                           arst_n,
	pdq_in_if.sink                         tick,
	pdq_out_if.source                      report,
	input  logic                           cfg_we,
	input  logic [pdq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pdq_pkg::*;

	pdq_cmd_t cmd;
	pdq_sts_t sts;

	pdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	pdq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.report    (report),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
